>>> src/pbpt_pkg.sv
package pbpt_pkg;

    // Sizes of the tracked content.
    localparam int MAX_PIECES  = 1024;
    localparam int MAX_BLOCKS  = 256;
    // Block size in bytes; must be a power of two.
    localparam int BLOCK_BYTES = 16384;

    // Field and register widths.
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int BEGIN_W    = 22;
    localparam int LEN_W      = 23;
    localparam int STATUS_W   = 2;
    localparam int PLEN_W     = 23;
    localparam int TOTAL_W    = 33;
    localparam int PCNT_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    // Derived sizes.
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int PSIZE_W     = TOTAL_W;
    localparam int BASE_W      = IDX_W + PLEN_W;
    localparam int END_W       = LEN_W + 1;
    localparam int MAP_W       = 64;
    localparam int BIT_W       = $clog2(MAP_W);
    localparam int WORDS       = (MAX_BLOCKS + MAP_W - 1) / MAP_W;
    localparam int WORD_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MAP_DEPTH   = MAX_PIECES * WORDS;
    localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int PIECE_AW    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int NBLK_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BIDX_A      = END_W - BLOCK_SHIFT;
    localparam int BIDX_B      = (NBLK_W > WORD_W + BIT_W) ? NBLK_W : WORD_W + BIT_W;
    localparam int BIDX_W      = (BIDX_A > BIDX_B) ? BIDX_A : BIDX_B;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_NOTICE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VERIFY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VERIFY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HASHFAIL = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_CNT = 2'd2;
    localparam logic [PLEN_W-1:0]    PLEN_RST      = 23'd262144;
    localparam logic [TOTAL_W-1:0]   TOTAL_RST     = 33'd1;
    localparam logic [PCNT_W-1:0]    PCNT_RST      = 11'd0;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_MAP_RD,
        S_MAP_WR,
        S_MAP_CLR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic calc1;
        logic calc2;
        logic calc3;
        logic clr_step;
        logic map_merge;
        logic map_zero;
        logic done_set;
        logic respond;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic             rng_err;
        logic             hash_ok;
        logic             word_last;
        logic             clr_last;
    } t_stat;

endpackage

>>> src/pbpt_ram.sv
module pbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pbpt_ctrl.sv
module pbpt_ctrl import pbpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CALC1;
                end
            end
            S_CALC1: n_state = S_CALC2;
            S_CALC2: n_state = S_CALC3;
            S_CALC3: begin
                n_state = S_IDLE;
                if (i_stat.valid) begin
                    case (i_stat.cmd)
                        CMD_NOTICE: begin
                            if (!i_stat.rng_err) begin
                                n_state = S_MAP_RD;
                            end
                        end
                        CMD_VERIFY: begin
                            if (!i_stat.hash_ok) begin
                                n_state = S_MAP_CLR;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MAP_RD: n_state = S_MAP_WR;
            S_MAP_WR: begin
                n_state = i_stat.word_last ? S_IDLE : S_MAP_RD;
            end
            S_MAP_CLR: begin
                if (i_stat.word_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: o_ctrl.clr_step = 1'b1;
            S_IDLE: begin
                o_busy      = 1'b0;
                o_ctrl.load = i_start;
            end
            S_CALC1: o_ctrl.calc1 = 1'b1;
            S_CALC2: o_ctrl.calc2 = 1'b1;
            S_CALC3: begin
                o_ctrl.calc3 = 1'b1;
                if (!i_stat.valid) begin
                    o_ctrl.respond = 1'b1;
                end else begin
                    case (i_stat.cmd)
                        CMD_NOTICE: o_ctrl.respond = i_stat.rng_err;
                        CMD_VERIFY: begin
                            o_ctrl.respond  = i_stat.hash_ok;
                            o_ctrl.done_set = i_stat.hash_ok;
                        end
                        default: o_ctrl.respond = 1'b1;
                    endcase
                end
            end
            S_MAP_RD: o_ctrl = '0;
            S_MAP_WR: begin
                o_ctrl.map_merge = 1'b1;
                o_ctrl.respond   = i_stat.word_last;
            end
            S_MAP_CLR: begin
                o_ctrl.map_zero = 1'b1;
                o_ctrl.respond  = i_stat.word_last;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

>>> src/pbpt_dpath.sv
module pbpt_dpath import pbpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [IDX_W-1:0]      i_piece_index,
    input  logic [BEGIN_W-1:0]    i_begin_req,
    input  logic [LEN_W-1:0]      i_length,
    input  logic                  i_hash_ok,
    input  t_ctrl                 i_ctrl,
    output t_stat                 o_stat,
    output logic                  o_result_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_piece_complete
);

    // Configuration registers.
    logic [PLEN_W-1:0]  r_piece_len;
    logic [TOTAL_W-1:0] r_total_len;
    logic [PCNT_W-1:0]  r_piece_cnt;

    // Captured transaction.
    logic [CMD_W-1:0]   r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [BEGIN_W-1:0] r_begin;
    logic [LEN_W-1:0]   r_len;
    logic               r_ok;

    // Working values.
    logic               r_valid;
    logic               r_is_last;
    logic [BASE_W-1:0]  r_base;
    logic               r_done;
    logic [END_W-1:0]   r_end;
    logic [PSIZE_W-1:0] r_psize;
    logic [NBLK_W-1:0]  r_nblk;
    logic               r_all;
    logic [WORD_W-1:0]  r_word;
    logic [MAP_AW-1:0]  r_clr;

    // Result registers.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic                r_complete;

    logic [PSIZE_W:0]    w_nblk_sum;
    logic [PSIZE_W:0]    w_nblk_div;
    logic [NBLK_W-1:0]   w_nblk;
    logic [PSIZE_W-1:0]  w_psize;
    logic [END_W-1:0]    w_end_m1;
    logic [BIDX_W-1:0]   w_first;
    logic [BIDX_W-1:0]   w_last;
    logic                w_mark_en;
    logic                w_rng_err;
    logic [MAP_W-1:0]    w_need;
    logic [MAP_W-1:0]    w_mark;
    logic [MAP_W-1:0]    w_merged;
    logic                w_word_full;
    logic                w_all_fin;
    logic [MAP_AW-1:0]   w_map_addr;
    logic                w_map_we;
    logic [MAP_AW-1:0]   w_map_waddr;
    logic [MAP_W-1:0]    w_map_wdata;
    logic [MAP_W-1:0]    w_map_rd;
    logic                w_clr_in_pieces;
    logic                w_done_we;
    logic [PIECE_AW-1:0] w_done_waddr;
    logic                w_done_rd;
    logic [STATUS_W-1:0] w_status;
    logic                w_complete;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece_len <= PLEN_RST;
            r_total_len <= TOTAL_RST;
            r_piece_cnt <= PCNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIECE_LEN: r_piece_len <= i_cfg_data[PLEN_W-1:0];
                CFG_TOTAL_LEN: r_total_len <= i_cfg_data[TOTAL_W-1:0];
                CFG_PIECE_CNT: r_piece_cnt <= i_cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture of the transaction fields.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_idx   <= i_piece_index;
            r_begin <= i_begin_req;
            r_len   <= i_length;
            r_ok    <= i_hash_ok;
        end
    end

    // First step: index check, start of the piece and end of the range.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc1) begin
            r_valid   <= ({1'b0, r_idx} < r_piece_cnt) && (32'(r_idx) < MAX_PIECES);
            r_is_last <= (PCNT_W'(r_idx) + PCNT_W'(1)) == r_piece_cnt;
            r_base    <= BASE_W'(r_idx) * BASE_W'(r_piece_len);
            r_done    <= w_done_rd;
            r_end     <= END_W'(r_begin) + END_W'(r_len);
        end
    end

    // Second step: size of the piece; the last piece takes what is left.
    always_comb begin
        if (!r_is_last) begin
            w_psize = PSIZE_W'(r_piece_len);
        end else if (PSIZE_W'(r_base) < r_total_len) begin
            w_psize = r_total_len - PSIZE_W'(r_base);
        end else begin
            w_psize = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc2) begin
            r_psize <= w_psize;
        end
    end

    // Third step: block count of the piece, capped.
    assign w_nblk_sum = (PSIZE_W + 1)'(r_psize) + (PSIZE_W + 1)'(BLOCK_BYTES - 1);
    assign w_nblk_div = w_nblk_sum >> BLOCK_SHIFT;
    assign w_nblk     = (w_nblk_div > (PSIZE_W + 1)'(MAX_BLOCKS)) ?
                        NBLK_W'(MAX_BLOCKS) : NBLK_W'(w_nblk_div);

    // Range check and covered blocks; an empty range marks nothing.
    assign w_rng_err = PSIZE_W'(r_end) > r_psize;
    assign w_end_m1  = r_end - END_W'(1);
    assign w_first   = BIDX_W'(r_begin >> BLOCK_SHIFT);
    assign w_last    = BIDX_W'(w_end_m1 >> BLOCK_SHIFT);
    assign w_mark_en = r_len != '0;

    // Bits of the current map word to set, and bits that must be present.
    always_comb begin
        logic [BIDX_W-1:0] bi;
        bi = '0;
        for (int k = 0; k < MAP_W; k++) begin
            bi        = BIDX_W'({r_word, BIT_W'(k)});
            w_need[k] = bi < BIDX_W'(r_nblk);
            w_mark[k] = w_mark_en && (bi >= w_first) && (bi <= w_last) && w_need[k];
        end
    end

    assign w_merged    = w_map_rd | w_mark;
    assign w_word_full = &(w_merged | ~w_need);
    assign w_all_fin   = r_all & (~i_ctrl.map_merge | w_word_full);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc3) begin
            r_nblk <= w_nblk;
            r_all  <= 1'b1;
        end else if (i_ctrl.map_merge) begin
            r_all  <= w_all_fin;
        end
    end

    // Word walk counter over the piece's map words.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_word <= '0;
        end else if (i_ctrl.map_merge || i_ctrl.map_zero) begin
            r_word <= r_word + WORD_W'(1);
        end
    end

    // Clearing pass counter after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctrl.clr_step) begin
            r_clr <= r_clr + MAP_AW'(1);
        end
    end

    // Block presence map.
    assign w_map_addr  = MAP_AW'(MAP_AW'(r_idx) * MAP_AW'(WORDS)) + MAP_AW'(r_word);
    assign w_map_we    = i_ctrl.clr_step || i_ctrl.map_merge || i_ctrl.map_zero;
    assign w_map_waddr = i_ctrl.clr_step ? r_clr : w_map_addr;
    assign w_map_wdata = i_ctrl.map_merge ? w_merged : '0;

    pbpt_ram #(
        .WIDTH(MAP_W),
        .DEPTH(MAP_DEPTH)
    ) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (w_map_we),
        .i_waddr(w_map_waddr),
        .i_wdata(w_map_wdata),
        .i_raddr(w_map_addr),
        .o_rdata(w_map_rd)
    );

    // Piece done map; read at the edge that accepts the transaction.
    assign w_clr_in_pieces = {1'b0, r_clr} < (MAP_AW + 1)'(MAX_PIECES);
    assign w_done_we       = (i_ctrl.clr_step && w_clr_in_pieces) || i_ctrl.done_set;
    assign w_done_waddr    = i_ctrl.clr_step ? PIECE_AW'(r_clr) : PIECE_AW'(r_idx);

    pbpt_ram #(
        .WIDTH(1),
        .DEPTH(MAX_PIECES)
    ) u_done_ram (
        .i_clk  (i_clk),
        .i_we   (w_done_we),
        .i_waddr(w_done_waddr),
        .i_wdata(i_ctrl.done_set),
        .i_raddr(PIECE_AW'(i_piece_index)),
        .o_rdata(w_done_rd)
    );

    // Result of the transaction.
    always_comb begin
        w_status   = ST_OK;
        w_complete = r_done;
        if (!r_valid) begin
            w_complete = 1'b0;
            if (r_cmd == CMD_NOTICE || r_cmd == CMD_VERIFY) begin
                w_status = ST_RANGE;
            end
        end else begin
            case (r_cmd)
                CMD_NOTICE: begin
                    if (w_rng_err) begin
                        w_status = ST_RANGE;
                    end else if (!r_done && w_all_fin) begin
                        w_status = ST_VERIFY;
                    end
                end
                CMD_VERIFY: begin
                    if (r_ok) begin
                        w_complete = 1'b1;
                    end else begin
                        w_status = ST_HASHFAIL;
                    end
                end
                CMD_QUERY: w_status = ST_OK;
                default:   w_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctrl.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.respond) begin
            r_status   <= w_status;
            r_complete <= w_complete;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.valid     = r_valid;
        o_stat.cmd       = r_cmd;
        o_stat.rng_err   = w_rng_err;
        o_stat.hash_ok   = r_ok;
        o_stat.word_last = r_word == WORD_W'(WORDS - 1);
        o_stat.clr_last  = r_clr == MAP_AW'(MAP_DEPTH - 1);
    end

    assign o_result_valid   = r_out_valid;
    assign o_status         = r_status;
    assign o_piece_complete = r_complete;

endmodule

>>> src/piece_block_presence_tracker.sv
// Channel     Ports                                        Transfer
// command     start, busy, i_cmd, i_piece_index,           start high and busy low
//             i_begin_req, i_length, i_hash_ok
// result      o_result_valid, o_status, o_piece_complete   one cycle, cannot stall
// config      i_cfg_we, i_cfg_index, i_cfg_data            i_cfg_we high, no wait
//
// A written-range notice that passes its checks runs three set-up steps, then a read
// and a write of the block map RAM for each of the four map words of the piece. A
// failed verify clears those words after the set-up steps, one word per cycle; other
// transactions, range errors included, end after the set-up steps. A new transaction
// is accepted in the cycle its predecessor's result is shown. After reset, busy stays
// high while both maps are cleared one word per cycle.
module piece_block_presence_tracker import pbpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [IDX_W-1:0]      i_piece_index,
    input  logic [BEGIN_W-1:0]    i_begin_req,
    input  logic [LEN_W-1:0]      i_length,
    input  logic                  i_hash_ok,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_piece_complete
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    // Sequencing.
    pbpt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (w_stat),
        .o_ctrl (w_ctrl),
        .o_busy (busy)
    );

    // Maps, piece size arithmetic and result formation.
    pbpt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_piece_index   (i_piece_index),
        .i_begin_req     (i_begin_req),
        .i_length        (i_length),
        .i_hash_ok       (i_hash_ok),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_piece_complete(o_piece_complete)
    );

endmodule

>>> src/pbpt_chk.sv
module pbpt_chk import pbpt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_result_valid,
    input logic [STATUS_W-1:0]   o_status,
    input logic                  o_piece_complete
);

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transaction");

    // Every transaction passes through the set-up states before its result, so results never follow back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    // A result appears only once the block is ready for the next transaction.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // A piece that needs hashing cannot already be done.
    a_verify_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_VERIFY) |-> !o_piece_complete)
        else $error("verify requested for a completed piece");

endmodule

bind piece_block_presence_tracker pbpt_chk u_pbpt_chk (.*);

>>> bench/piece_block_presence_tracker_tb.sv
`timescale 1ns / 100ps

module piece_block_presence_tracker_tb;
    import pbpt_pkg::*;

    // Command code with no function of its own; the block answers it as a query.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam longint unsigned RANGE_MAX  = 64'd1 << (LEN_W - 1);
    localparam longint unsigned TOTAL_MAX  = 64'd1 << 32;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                complete;
    } t_tracker_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [CMD_W-1:0]      i_cmd = CMD_QUERY;
    logic [IDX_W-1:0]      i_piece_index = '0;
    logic [BEGIN_W-1:0]    i_begin_req = '0;
    logic [LEN_W-1:0]      i_length = '0;
    logic                  i_hash_ok = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PIECE_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_result_valid;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_piece_complete;

    // Shadow copy of the configuration and of both maps.
    bit [PLEN_W-1:0]     cfg_plen = PLEN_RST;
    bit [TOTAL_W-1:0]    cfg_total = TOTAL_RST;
    bit [PCNT_W-1:0]     cfg_pcnt = PCNT_RST;
    bit [MAX_BLOCKS-1:0] blocks_seen [MAX_PIECES];
    bit                  piece_verified [MAX_PIECES];

    t_tracker_answer pending_answers [$];
    int unsigned     items_sent = 0;
    int unsigned     burst_left = 0;
    int unsigned     mismatches = 0;
    int unsigned     idle_cycles = 0;

    piece_block_presence_tracker uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_piece_index    (i_piece_index),
        .i_begin_req      (i_begin_req),
        .i_length         (i_length),
        .i_hash_ok        (i_hash_ok),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_piece_complete (o_piece_complete)
    );

    always #6 i_clk = ~i_clk;

    // Size of a piece in bytes; only the last piece may be shorter, or even empty.
    function automatic longint unsigned piece_bytes(input int unsigned idx);
        longint unsigned base;
        if (idx + 1 != cfg_pcnt) begin
            return cfg_plen;
        end
        base = longint'(idx) * longint'(cfg_plen);
        return (cfg_total > base) ? cfg_total - base : 64'd0;
    endfunction

    // Applies one transaction to the shadow maps and returns the answer it should get.
    function automatic t_tracker_answer piece_answer(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [BEGIN_W-1:0] beg,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic ok);
        t_tracker_answer     ans;
        longint unsigned     psize;
        longint unsigned     first_blk;
        longint unsigned     last_blk;
        longint unsigned     b;
        int unsigned         nblk;
        bit [MAX_BLOCKS-1:0] mask;
        ans.status   = ST_OK;
        ans.complete = 1'b0;
        if (idx >= cfg_pcnt) begin
            if (cmd == CMD_NOTICE || cmd == CMD_VERIFY) begin
                ans.status = ST_RANGE;
            end
            return ans;
        end
        case (cmd)
            CMD_NOTICE: begin
                psize = piece_bytes(idx);
                nblk  = 32'((psize + BLOCK_BYTES - 1) / BLOCK_BYTES);
                if (nblk > MAX_BLOCKS) begin
                    nblk = MAX_BLOCKS;
                end
                if (longint'(beg) + longint'(len) > psize) begin
                    ans.status = ST_RANGE;
                end else begin
                    // Blocks past the end of the piece's block count are not marked.
                    if (len != 0) begin
                        first_blk = beg / BLOCK_BYTES;
                        last_blk  = (longint'(beg) + longint'(len) - 1) / BLOCK_BYTES;
                        for (b = first_blk; b <= last_blk && b < nblk; b++) begin
                            blocks_seen[idx][b] = 1'b1;
                        end
                    end
                    // A piece with no blocks at all counts as complete.
                    mask = {MAX_BLOCKS{1'b1}} >> (MAX_BLOCKS - nblk);
                    if (!piece_verified[idx] && (blocks_seen[idx] & mask) == mask) begin
                        ans.status = ST_VERIFY;
                    end
                end
            end
            CMD_VERIFY: begin
                if (ok) begin
                    piece_verified[idx] = 1'b1;
                end else begin
                    blocks_seen[idx] = '0;
                    ans.status       = ST_HASHFAIL;
                end
            end
            default: begin
            end
        endcase
        ans.complete = piece_verified[idx];
        return ans;
    endfunction

    // Result checker: every strobe must match the oldest outstanding transaction.
    always @(posedge i_clk) begin
        t_tracker_answer want;
        if (i_rst_n && o_result_valid) begin
            if (pending_answers.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_piece_complete !== want.complete) begin
                    $error("piece_complete: expected %0d, got %0d", want.complete,
                           o_piece_complete);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with neither an accepted transaction nor a result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one transaction; the sender idles in random gaps between bursts.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [BEGIN_W-1:0] beg, input logic [LEN_W-1:0] len,
                             input logic ok);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_piece_index <= idx;
        i_begin_req   <= beg;
        i_length      <= len;
        i_hash_ok     <= ok;
        do @(posedge i_clk); while (busy);
        pending_answers.push_back(piece_answer(cmd, idx, beg, len, ok));
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers back to back; only called with the block idle.
    task automatic set_config(input longint unsigned plen, input longint unsigned total,
                              input longint unsigned pcnt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PIECE_LEN;
        i_cfg_data  <= CFG_DATA_W'(plen);
        @(posedge i_clk);
        cfg_plen    = plen[PLEN_W-1:0];
        i_cfg_index <= CFG_TOTAL_LEN;
        i_cfg_data  <= CFG_DATA_W'(total);
        @(posedge i_clk);
        cfg_total   = total[TOTAL_W-1:0];
        i_cfg_index <= CFG_PIECE_CNT;
        i_cfg_data  <= CFG_DATA_W'(pcnt);
        @(posedge i_clk);
        cfg_pcnt    = pcnt[PCNT_W-1:0];
        i_cfg_we    <= 1'b0;
    endtask

    // With the reset configuration no piece is in use.
    task automatic test_after_reset();
        send_item(CMD_NOTICE, 0, 0, 16384, 1'b0);
        send_item(CMD_VERIFY, 0, 0, 0, 1'b1);
        send_item(CMD_QUERY, 0, 0, 0, 1'b0);
        send_item(CMD_SPARE, 1023, 4194303, LEN_W'(RANGE_MAX), 1'b1);
    endtask

    // Four-block pieces with a one-block last piece of 100 bytes.
    task automatic test_notice_ranges();
        drain_results();
        set_config(65536, 3 * 65536 + 100, 4);
        send_item(CMD_NOTICE, 0, 0, 0, 1'b0);
        send_item(CMD_NOTICE, 0, 0, 16384, 1'b0);
        send_item(CMD_NOTICE, 0, 16384, 49152, 1'b0);
        send_item(CMD_NOTICE, 0, 65535, 2, 1'b0);
        send_item(CMD_NOTICE, 3, 0, 100, 1'b0);
        send_item(CMD_NOTICE, 3, 100, 0, 1'b0);
        send_item(CMD_NOTICE, 4, 0, 1, 1'b0);
        send_item(CMD_NOTICE, 1, 4194303, LEN_W'(RANGE_MAX), 1'b1);
    endtask

    // Hash failures clear blocks but keep the done bit; matches set it.
    task automatic test_verify_results();
        send_item(CMD_VERIFY, 0, 0, 0, 1'b0);
        send_item(CMD_NOTICE, 0, 0, 65536, 1'b0);
        send_item(CMD_VERIFY, 0, 0, 0, 1'b1);
        send_item(CMD_NOTICE, 0, 0, 16384, 1'b0);
        send_item(CMD_VERIFY, 0, 0, 0, 1'b0);
        send_item(CMD_QUERY, 0, 0, 0, 1'b0);
        send_item(CMD_VERIFY, 1, 0, 0, 1'b1);
        send_item(CMD_QUERY, 2, 0, 0, 1'b0);
    endtask

    // Largest pieces, a last piece past the block cap, and an empty last piece.
    task automatic test_size_extremes();
        drain_results();
        set_config(RANGE_MAX, TOTAL_MAX, MAX_PIECES);
        send_item(CMD_NOTICE, 1023, 0, LEN_W'(RANGE_MAX), 1'b0);
        send_item(CMD_NOTICE, 1022, 4194303, 1, 1'b0);
        drain_results();
        set_config(1, TOTAL_MAX, 1);
        send_item(CMD_NOTICE, 0, 4194303, LEN_W'(RANGE_MAX), 1'b0);
        send_item(CMD_NOTICE, 0, 0, LEN_W'(RANGE_MAX), 1'b0);
        drain_results();
        set_config(100, 150, 3);
        send_item(CMD_NOTICE, 2, 0, 0, 1'b0);
        send_item(CMD_NOTICE, 2, 0, 1, 1'b0);
    endtask

    // Covers a piece in a few written ranges, then verifies and maybe queries it.
    task automatic send_piece_sequence(input int unsigned idx);
        longint unsigned span;
        longint unsigned pos;
        longint unsigned step;
        int unsigned     chunks;
        span = piece_bytes(idx);
        if (span > RANGE_MAX) begin
            span = RANGE_MAX;
        end
        chunks = $urandom_range(1, 4);
        pos    = 0;
        if (span == 0) begin
            send_item(CMD_NOTICE, IDX_W'(idx), 0, 0, 1'($urandom));
        end
        while (pos < span) begin
            step = (chunks <= 1) ? span - pos : $urandom_range(1, 32'(span - pos));
            send_item(CMD_NOTICE, IDX_W'(idx), BEGIN_W'(pos), LEN_W'(step), 1'($urandom));
            pos += step;
            if (chunks > 1) begin
                chunks--;
            end
        end
        send_item(CMD_VERIFY, IDX_W'(idx), BEGIN_W'($urandom), LEN_W'($urandom),
                  $urandom_range(0, 4) != 0);
        if ($urandom_range(0, 1)) begin
            send_item(CMD_QUERY, IDX_W'(idx), BEGIN_W'($urandom), LEN_W'($urandom),
                      1'($urandom));
        end
    endtask

    // Stray traffic: random fields, partial ranges, lone verifies and queries.
    task automatic send_noise_item();
        int unsigned     idx;
        longint unsigned psize;
        longint unsigned beg;
        longint unsigned len;
        idx = (cfg_pcnt != 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, cfg_pcnt - 1)
                                                          : $urandom_range(0, MAX_PIECES - 1);
        case ($urandom_range(0, 3))
            0: begin
                send_item(CMD_W'($urandom_range(0, 3)), IDX_W'(idx),
                          BEGIN_W'($urandom_range(0, 4194303)),
                          LEN_W'($urandom_range(0, 32'(RANGE_MAX))), 1'($urandom));
            end
            1: begin
                psize = piece_bytes(idx);
                beg   = (psize == 0) ? 0 : $urandom_range(0, (psize > RANGE_MAX) ? RANGE_MAX - 1
                                                                               : psize - 1);
                len   = psize - beg;
                if (len > RANGE_MAX) begin
                    len = RANGE_MAX;
                end
                send_item(CMD_NOTICE, IDX_W'(idx), BEGIN_W'(beg),
                          LEN_W'($urandom_range(0, 32'(len))), 1'($urandom));
            end
            2: begin
                send_item(CMD_VERIFY, IDX_W'(idx), BEGIN_W'($urandom), LEN_W'($urandom),
                          1'($urandom));
            end
            default: begin
                send_item(($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_QUERY, IDX_W'(idx),
                          BEGIN_W'($urandom), LEN_W'($urandom), 1'($urandom));
            end
        endcase
    endtask

    // Random traffic over several configurations, extremes included.
    task automatic test_random_traffic();
        int unsigned     phase_items [6] = '{260, 180, 60, 240, 250, 40};
        longint unsigned plen;
        longint unsigned total;
        longint unsigned pcnt;
        int unsigned     sent_before;
        int              phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    plen  = BLOCK_BYTES * $urandom_range(1, 4);
                    pcnt  = $urandom_range(1, 8);
                    total = (pcnt - 1) * plen + $urandom_range(1, plen);
                end
                1: begin
                    plen  = RANGE_MAX;
                    total = TOTAL_MAX;
                    pcnt  = MAX_PIECES;
                end
                2: begin
                    plen  = 1;
                    total = 1;
                    pcnt  = 1;
                end
                3: begin
                    plen  = $urandom_range(1, RANGE_MAX);
                    total = ($urandom_range(0, 3) == 0) ? TOTAL_MAX
                                                        : $urandom_range(1, 32'hFFFF_FFFF);
                    pcnt  = $urandom_range(0, MAX_PIECES);
                end
                4: begin
                    plen  = $urandom_range(1, 40000);
                    total = $urandom_range(1, 1100 * plen);
                    pcnt  = MAX_PIECES;
                end
                default: begin
                    plen  = $urandom_range(1, RANGE_MAX);
                    total = $urandom_range(1, 32'hFFFF_FFFF);
                    pcnt  = 0;
                end
            endcase
            drain_results();
            set_config(plen, total, pcnt);
            sent_before = items_sent;
            while (items_sent - sent_before < phase_items[phase]) begin
                if (pcnt != 0 && $urandom_range(0, 9) < 7) begin
                    send_piece_sequence($urandom_range(0, pcnt - 1));
                end else begin
                    send_noise_item();
                end
            end
        end
    endtask

    // Reset once, wait out the clearing pass, then run the tests in turn.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        test_after_reset();
        test_notice_ranges();
        test_verify_results();
        test_size_extremes();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/pbpt_pkg.sv
src/pbpt_ram.sv
src/pbpt_ctrl.sv
src/pbpt_dpath.sv
src/piece_block_presence_tracker.sv
src/pbpt_chk.sv
bench/piece_block_presence_tracker_tb.sv
